// File: rtl/rdtfp_pkg.sv
// ----------------------------------------------------------------------------
// rdtfp_pkg
// Types and constants for the feedback packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rdtfp_pkg;

  localparam int unsigned POS_W = 9;

  localparam logic [POS_W-1:0] POS_MAX    = 9'd511;
  localparam logic [POS_W-1:0] MARKER_POS = 9'd9;
  localparam logic [POS_W-1:0] TYPE_POS   = 9'd62;
  localparam logic [POS_W-1:0] FIELD1_POS = 9'd63;
  localparam logic [POS_W-1:0] FIELD2_POS = 9'd64;
  localparam logic [POS_W-1:0] FIELD3_POS = 9'd65;

  localparam logic [7:0] MARKER_RESET = 8'h19;

  localparam logic [7:0] MSG_META = 8'd0;
  localparam logic [7:0] MSG_ACK  = 8'd2;
  localparam logic [7:0] MSG_NACK = 8'd3;

  localparam int unsigned FIFO_DEPTH_DEF = 4;

  typedef enum logic [2:0] {
    KIND_META = 3'd0,
    KIND_ACK  = 3'd1,
    KIND_NACK = 3'd2,
    KIND_DROP = 3'd3,
    KIND_PASS = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] index_value;
    logic [7:0] fsize;
    logic [7:0] data_size;
    logic [7:0] ack_mode;
    logic [7:0] packets;
    logic       last;
  } rec_t;

  typedef struct packed {
    logic [1:0] num;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

endpackage

`default_nettype wire

// File: rtl/rdt_feedback_packet_parser.sv
// ----------------------------------------------------------------------------
// rdt_feedback_packet_parser
// Streaming parser for sender feedback packets, one byte per item.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in_      in_valid / in_stall  in_packet_byte, in_end_of_packet
//  out_     out_valid/out_stall  record fields, out_last_of_run
//  cfg_     cfg_valid/cfg_ready  cfg_data (protocol marker)
//
//  One byte is accepted per cycle while in_stall is low; its records enter the
//  result queue at the same edge and show on out_ from the next cycle if the queue held no records before.
//  A byte yields up to two records; the queue drains one per cycle while out_stall is low.
//  in_stall rises when the queue has room for fewer than two records.
//  Synchronous active-low reset; marker resets to 0x19.
// ----------------------------------------------------------------------------
`default_nettype none

module rdt_feedback_packet_parser #(
  parameter int unsigned FIFO_DEPTH = rdtfp_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_packet_byte,
  input  wire logic       in_end_of_packet,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_record_kind,
  output logic [7:0]      out_index_value,
  output logic [7:0]      out_file_size_seen,
  output logic [7:0]      out_data_size_seen,
  output logic [7:0]      out_ack_mode_seen,
  output logic [7:0]      out_packets_counted,
  output logic            out_last_of_run,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);
  import rdtfp_pkg::*;

  logic [7:0] marker_r;
  logic       accept;
  push_t      push;
  rec_t       head;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= MARKER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      marker_r <= cfg_data;
    end
  end

  rdtfp_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .pkt_byte (in_packet_byte),
    .eop      (in_end_of_packet),
    .marker   (marker_r),
    .push     (push)
  );

  rdtfp_rec_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (in_stall),
    .head       (head),
    .head_valid (out_valid),
    .head_stall (out_stall)
  );

  assign out_record_kind     = head.kind;
  assign out_index_value     = head.index_value;
  assign out_file_size_seen  = head.fsize;
  assign out_data_size_seen  = head.data_size;
  assign out_ack_mode_seen   = head.ack_mode;
  assign out_packets_counted = head.packets;
  assign out_last_of_run     = head.last;

endmodule

`default_nettype wire

// File: rtl/rdtfp_parser.sv
// ----------------------------------------------------------------------------
// rdtfp_parser
// Per-byte parse state and record generation for one accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

module rdtfp_parser (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept,
  input  wire logic [7:0]     pkt_byte,
  input  wire logic           eop,
  input  wire logic [7:0]     marker,
  output rdtfp_pkg::push_t    push
);
  import rdtfp_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             mm_r, mm_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [7:0]       list_r, list_nxt;
  logic [7:0]       fs_r, fs_nxt;
  logic [7:0]       ds_r, ds_nxt;
  logic [7:0]       am_r, am_nxt;
  logic [7:0]       cnt_r, cnt_nxt;

  logic       mm_cur, at_type, past_type;
  logic [7:0] type_cur, list_cur, fs_cur, ds_cur;
  logic       is_meta, is_ack, is_nack;
  logic       meta_hit, ack_hit, nack_hit, data_hit;
  logic       drop, inc;
  rec_t       data_rec, verd_rec;

  always_comb begin
    mm_cur    = (pos_r == MARKER_POS) ? (pkt_byte == marker) : mm_r;
    at_type   = mm_cur && (pos_r == TYPE_POS);
    past_type = mm_cur && (pos_r > TYPE_POS);
    type_cur  = at_type ? pkt_byte : type_r;
    is_meta   = (type_cur == MSG_META);
    is_ack    = (type_cur == MSG_ACK);
    is_nack   = (type_cur == MSG_NACK);

    list_cur = (past_type && is_ack && (pos_r == FIELD1_POS)) ? pkt_byte : list_r;
    fs_cur   = (past_type && is_meta && (pos_r == FIELD1_POS)) ? pkt_byte : fs_r;
    ds_cur   = (past_type && is_meta && (pos_r == FIELD2_POS)) ? pkt_byte : ds_r;

    meta_hit = past_type && is_meta && (pos_r == FIELD3_POS);
    ack_hit  = past_type && is_ack && (pos_r >= FIELD2_POS) &&
               ({1'b0, pos_r} < ({1'b0, FIELD2_POS} + {2'b00, list_r}));
    nack_hit = past_type && is_nack && (pos_r == FIELD1_POS);
    data_hit = meta_hit || ack_hit || nack_hit;

    drop = 1'b0;
    if (mm_cur && (pos_r >= TYPE_POS)) begin
      priority if (is_meta) begin
        drop = (pos_r >= FIELD3_POS);
      end else if (is_ack) begin
        drop = ({1'b0, pos_r} >= ({1'b0, FIELD1_POS} + {2'b00, list_cur}));
      end else if (is_nack) begin
        drop = (pos_r >= FIELD1_POS);
      end else begin
        drop = 1'b1;
      end
    end

    inc     = accept && ((at_type && (pkt_byte == MSG_META)) || (eop && drop && !is_meta));
    cnt_nxt = cnt_r + {7'd0, inc};

    data_rec.kind        = meta_hit ? KIND_META : (ack_hit ? KIND_ACK : KIND_NACK);
    data_rec.index_value = meta_hit ? 8'd0 : pkt_byte;
    data_rec.fsize       = meta_hit ? fs_r : 8'd0;
    data_rec.data_size   = meta_hit ? ds_r : 8'd0;
    data_rec.ack_mode    = meta_hit ? pkt_byte : 8'd0;
    data_rec.packets     = 8'd0;
    data_rec.last        = !eop;

    verd_rec.kind        = drop ? KIND_DROP : KIND_PASS;
    verd_rec.index_value = 8'd0;
    verd_rec.fsize       = 8'd0;
    verd_rec.data_size   = 8'd0;
    verd_rec.ack_mode    = 8'd0;
    verd_rec.packets     = cnt_nxt;
    verd_rec.last        = 1'b1;

    push.num  = accept ? ({1'b0, data_hit} + {1'b0, eop}) : 2'd0;
    push.rec0 = data_hit ? data_rec : verd_rec;
    push.rec1 = verd_rec;

    pos_nxt  = pos_r;
    mm_nxt   = mm_r;
    type_nxt = type_r;
    list_nxt = list_r;
    fs_nxt   = fs_r;
    ds_nxt   = ds_r;
    am_nxt   = am_r;
    if (accept) begin
      fs_nxt = fs_cur;
      ds_nxt = ds_cur;
      am_nxt = meta_hit ? pkt_byte : am_r;
      if (eop) begin
        pos_nxt  = '0;
        mm_nxt   = 1'b0;
        type_nxt = 8'd0;
        list_nxt = 8'd0;
      end else begin
        pos_nxt  = (pos_r < POS_MAX) ? pos_r + 9'd1 : POS_MAX;
        mm_nxt   = mm_cur;
        type_nxt = type_cur;
        list_nxt = list_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      mm_r   <= 1'b0;
      type_r <= 8'd0;
      list_r <= 8'd0;
      fs_r   <= 8'd0;
      ds_r   <= 8'd0;
      am_r   <= 8'd0;
      cnt_r  <= 8'd0;
    end else begin
      pos_r  <= pos_nxt;
      mm_r   <= mm_nxt;
      type_r <= type_nxt;
      list_r <= list_nxt;
      fs_r   <= fs_nxt;
      ds_r   <= ds_nxt;
      am_r   <= am_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rdtfp_rec_fifo.sv
// ----------------------------------------------------------------------------
// rdtfp_rec_fifo
// Result queue: takes up to two records per cycle, hands out one while head_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module rdtfp_rec_fifo #(
  parameter int unsigned DEPTH = rdtfp_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire rdtfp_pkg::push_t push,
  output logic                  full,
  output rdtfp_pkg::rec_t       head,
  output logic                  head_valid,
  input  wire logic             head_stall
);
  import rdtfp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_ROOM = CNT_W'(DEPTH - 2);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    ptr_inc = (ptr == PTR_LAST) ? '0 : ptr + PTR_W'(1);
  endfunction

  rec_t mem_r [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_2;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;

  always_comb begin
    pop        = head_valid && !head_stall;
    wr_ptr_2   = ptr_inc(wr_ptr_r);
    wr_ptr_nxt = (push.num == 2'd2) ? ptr_inc(wr_ptr_2) :
                 (push.num == 2'd1) ? wr_ptr_2 : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push.num) - CNT_W'(pop);
  end

  assign full       = (count_r > CNT_ROOM);
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem_r[wr_ptr_r] <= push.rec0;
    end
    if (push.num == 2'd2) begin
      mem_r[wr_ptr_2] <= push.rec1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("record queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.num != 2'd0) |-> (({1'b0, count_r} + (CNT_W + 1)'(push.num)) <= (CNT_W + 1)'(DEPTH)))
    else $error("record queue overflow");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (push.num == 2'd2) |-> (push.rec1.last && !push.rec0.last))
    else $error("record pair out of order");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == CNT_W'(1) && pop && push.num == 2'd0) |=> !head_valid)
    else $error("record queue failed to drain");

endmodule

`default_nettype wire
